// ===== src/srfq_pkg.sv =====
// srfq_pkg: shared constants, types and helpers for the scan record framer queue.
// No dependencies; the design files and the bench refer to it by scoped names.
package srfq_pkg;

    localparam int RING_RECORDS  = 32;
    localparam int BATCH_RECORDS = 4;
    localparam int RECORD_BYTES  = 160;
    localparam int REC_WORDS     = RECORD_BYTES / 8;
    localparam int MAX_SAMPLES   = 65;

    localparam int SLOT_W  = $clog2(RING_RECORDS);
    localparam int CNT_W   = $clog2(RING_RECORDS + 1);
    localparam int ADDR_W  = $clog2(RING_RECORDS * REC_WORDS);
    localparam int WORD_W  = $clog2(REC_WORDS);
    localparam int PADDR_W = 3;

    localparam logic [WORD_W-1:0] FIRST_SAMPLE_WORD = WORD_W'(3);
    localparam logic [WORD_W-1:0] SUM_WORD          = WORD_W'(REC_WORDS - 1);
    localparam logic [3:0]        LAST_BEAT         = 4'(REC_WORDS / 2 - 1);
    localparam logic [31:0]       MAGIC_WORD        = 32'h3153_4B48;
    localparam logic [15:0]       REC_LEN           = 16'(RECORD_BYTES);
    localparam logic [15:0]       CEILING_RESET     = 16'd4096;
    // halfword sum of magic and length
    localparam logic [19:0]       HDR_CONST_SUM     = 20'h04B48 + 20'h03153 + 20'(RECORD_BYTES);

    localparam logic [0:0] REG_CEILING = 1'b0;

    typedef enum logic [2:0] {
        OP_BEGIN    = 3'd0,
        OP_SAMPLE   = 3'd1,
        OP_SERVICE  = 3'd2,
        OP_XFER_DONE = 3'd3,
        OP_LINK_RST = 3'd4,
        OP_START    = 3'd5,
        OP_STOP     = 3'd6
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMMIT,
        S_RD_LO,
        S_RD_HI,
        S_BEAT,
        S_STATUS
    } t_state;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  sample_count;
        logic [7:0]  profile;
        logic [31:0] tick;
        logic [15:0] sample;
        logic        link_ready;
        logic        link_accept;
    } t_item;

    typedef struct packed {
        logic accept;
        logic commit;
        logic rd_lo;
        logic rd_hi;
        logic load_beat;
        logic load_status;
    } t_cmd;

    typedef struct packed {
        logic go_commit;
        logic go_batch;
        logic commit_done;
        logic last_beat;
        logic out_free;
    } t_stat;

    // sample words past the record's sample count read as zero
    function automatic logic word_kept(input logic [WORD_W-1:0] word, input logic [6:0] cnt);
        logic [6:0] first;
        first = {word - FIRST_SAMPLE_WORD, 2'b00};
        if (word < FIRST_SAMPLE_WORD || word == SUM_WORD) begin
            return 1'b1;
        end
        return first < cnt;
    endfunction

endpackage

// ===== src/srfq_item_if.sv =====
// srfq_item_if: input item channel (valid/ready plus item fields).
// Depends on nothing.
interface srfq_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [7:0]  sample_count;
    logic [7:0]  profile;
    logic [31:0] tick;
    logic [15:0] sample;
    logic        link_ready;
    logic        link_accept;

    modport source (output valid, opcode, sample_count, profile, tick, sample, link_ready,
                    link_accept, input ready);
    modport sink (input valid, opcode, sample_count, profile, tick, sample, link_ready,
                  link_accept, output ready);
endinterface

// ===== src/srfq_result_if.sv =====
// srfq_result_if: result channel (valid/ready plus beat and status fields).
// Depends on nothing.
interface srfq_result_if;
    logic        valid;
    logic        ready;
    logic        beat_valid;
    logic [63:0] beat_low;
    logic [63:0] beat_high;
    logic        beat_last;
    logic        owns_link;
    logic        stream_enabled;
    logic [31:0] dropped_total;
    logic [5:0]  queued_records;

    modport source (output valid, beat_valid, beat_low, beat_high, beat_last, owns_link,
                    stream_enabled, dropped_total, queued_records, input ready);
    modport sink (input valid, beat_valid, beat_low, beat_high, beat_last, owns_link,
                  stream_enabled, dropped_total, queued_records, output ready);
endinterface

// ===== src/scan_record_framer_queue_top.sv =====
// scan_record_framer_queue_top: channels, APB register and controller/datapath hookup.
// Depends on srfq_pkg, srfq_item_if, srfq_result_if, srfq_ctrl, srfq_datapath.
//
//   channel   | dir | handshake      | carries
//   ----------+-----+----------------+------------------------------------------
//   i_item    | in  | valid/ready    | opcode, count, profile, tick, sample, link
//   o_result  | out | valid/ready    | beat bytes, last flag, status snapshot
//   apb       | in  | psel/penable   | sample_ceiling at byte address 0
//
// One item at a time: a plain item is accepted, then its status word is loaded.
// A sample that completes a record adds a commit pass, one store write per step.
// A service batch is accepted, then each beat takes two store reads, then a load;
// ten beats per record, up to four records; the single store read port keeps the reads serial.
// Output stalls hold the sequencer in its load state. Synchronous reset; no clearing pass.
module scan_record_framer_queue_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    srfq_item_if.sink                     i_item,
    srfq_result_if.source                 o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srfq_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    srfq_pkg::t_item item;
    srfq_pkg::t_cmd  cmd;
    srfq_pkg::t_stat stat;
    logic [15:0]     r_ceiling;
    logic            in_ready;
    logic            reg_sel;

    assign item.opcode       = i_item.opcode;
    assign item.sample_count = i_item.sample_count;
    assign item.profile      = i_item.profile;
    assign item.tick         = i_item.tick;
    assign item.sample       = i_item.sample;
    assign item.link_ready   = i_item.link_ready;
    assign item.link_accept  = i_item.link_accept;
    assign i_item.ready      = in_ready;

    assign pready  = 1'b1;
    assign reg_sel = paddr[srfq_pkg::PADDR_W-1:2] == srfq_pkg::REG_CEILING;
    assign prdata  = reg_sel ? {16'd0, r_ceiling} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling <= srfq_pkg::CEILING_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_ceiling <= pwdata[15:0];
        end
    end

    srfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    srfq_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item           (item),
        .i_cmd            (cmd),
        .i_ceiling        (r_ceiling),
        .i_out_ready      (o_result.ready),
        .o_stat           (stat),
        .o_out_valid      (o_result.valid),
        .o_beat_valid     (o_result.beat_valid),
        .o_beat_low       (o_result.beat_low),
        .o_beat_high      (o_result.beat_high),
        .o_beat_last      (o_result.beat_last),
        .o_owns_link      (o_result.owns_link),
        .o_stream_enabled (o_result.stream_enabled),
        .o_dropped_total  (o_result.dropped_total),
        .o_queued_records (o_result.queued_records)
    );

endmodule

// ===== src/srfq_ctrl.sv =====
// srfq_ctrl: sequencing state machine for item handling, record commit and beat output.
// Depends on srfq_pkg.
module srfq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  srfq_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output srfq_pkg::t_cmd  o_cmd
);

    srfq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srfq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            srfq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.go_commit) begin
                        n_state = srfq_pkg::S_COMMIT;
                    end else if (i_stat.go_batch) begin
                        n_state = srfq_pkg::S_RD_LO;
                    end else begin
                        n_state = srfq_pkg::S_STATUS;
                    end
                end
            end
            srfq_pkg::S_COMMIT: begin
                o_cmd.commit = 1'b1;
                if (i_stat.commit_done) begin
                    n_state = srfq_pkg::S_STATUS;
                end
            end
            srfq_pkg::S_RD_LO: begin
                o_cmd.rd_lo = 1'b1;
                n_state = srfq_pkg::S_RD_HI;
            end
            srfq_pkg::S_RD_HI: begin
                o_cmd.rd_hi = 1'b1;
                n_state = srfq_pkg::S_BEAT;
            end
            srfq_pkg::S_BEAT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_beat = 1'b1;
                    n_state = i_stat.last_beat ? srfq_pkg::S_IDLE : srfq_pkg::S_RD_LO;
                end
            end
            srfq_pkg::S_STATUS: begin
                if (i_stat.out_free) begin
                    o_cmd.load_status = 1'b1;
                    n_state = srfq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = srfq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/srfq_datapath.sv =====
// srfq_datapath: ring state, record store, record assembly and output register.
// Depends on srfq_pkg; driven by srfq_ctrl commands.
module srfq_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  srfq_pkg::t_item i_item,
    input  srfq_pkg::t_cmd  i_cmd,
    input  logic [15:0]     i_ceiling,
    input  logic            i_out_ready,
    output srfq_pkg::t_stat o_stat,
    output logic            o_out_valid,
    output logic            o_beat_valid,
    output logic [63:0]     o_beat_low,
    output logic [63:0]     o_beat_high,
    output logic            o_beat_last,
    output logic            o_owns_link,
    output logic            o_stream_enabled,
    output logic [31:0]     o_dropped_total,
    output logic [5:0]      o_queued_records
);

    localparam int SW = srfq_pkg::SLOT_W;
    localparam int CW = srfq_pkg::CNT_W;
    localparam int AW = srfq_pkg::ADDR_W;
    localparam int WW = srfq_pkg::WORD_W;

    // control state
    logic [SW-1:0] r_write_slot, n_write_slot, r_read_slot, n_read_slot;
    logic [CW-1:0] r_queued, n_queued;
    logic [31:0]   r_seq, n_seq, r_drop, n_drop;
    logic          r_stream, n_stream, r_busy, n_busy, r_pending, n_pending;
    logic          r_assembling, n_assembling;
    logic [6:0]    r_taken, n_taken;
    logic [1:0]    r_cstep, n_cstep;
    logic [2:0]    r_brem, n_brem;
    logic          r_out_valid, n_out_valid;

    // payload
    logic [6:0]    r_h_cnt, n_h_cnt;
    logic [7:0]    r_h_prof, n_h_prof;
    logic [31:0]   r_h_seq, n_h_seq, r_h_tick, n_h_tick, r_h_drop, n_h_drop;
    logic          r_range, n_range;
    logic [22:0]   r_smp_sum, n_smp_sum;
    logic [19:0]   r_hdr_sum, n_hdr_sum;
    logic [63:0]   r_acc, n_acc;
    logic [SW-1:0] r_bslot, n_bslot;
    logic [3:0]    r_bword, n_bword;
    logic [63:0]   r_rdata, r_lo_q, n_lo_q;
    logic          r_o_bv, n_o_bv, r_o_last, n_o_last, r_o_own, n_o_own, r_o_str, n_o_str;
    logic [63:0]   r_o_lo, n_o_lo, r_o_hi, n_o_hi;
    logic [31:0]   r_o_drop, n_o_drop;
    logic [5:0]    r_o_q, n_o_q;

    logic [63:0]   mem [srfq_pkg::RING_RECORDS * srfq_pkg::REC_WORDS];
    logic [6:0]    r_slot_cnt [srfq_pkg::RING_RECORDS];

    logic          we, rd_en, cnt_we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0]   wdata;

    // item decode
    logic          begin_ok, begin_drop, flush_svc, batch_ok, smp_ok, smp_last;
    logic [CW-1:0] q_svc;
    logic [SW-1:0] rs_svc;
    logic [2:0]    n_batch;
    logic [1:0]    lane;
    logic [WW-1:0] sword, wlo, whi;
    logic [6:0]    cnt7;
    logic [31:0]   q32, sum32;
    logic [SW:0]   slot_sum;

    function automatic logic [AW-1:0] rec_base(input logic [SW-1:0] slot);
        return AW'(slot) * AW'(srfq_pkg::REC_WORDS);
    endfunction

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] slot);
        return (slot == SW'(srfq_pkg::RING_RECORDS - 1)) ? '0 : slot + SW'(1);
    endfunction

    assign cnt7       = i_item.sample_count[6:0];
    assign begin_ok   = r_stream && i_item.sample_count != 8'd0
                        && i_item.sample_count <= 8'(srfq_pkg::MAX_SAMPLES);
    assign q32        = 32'(r_queued);
    assign begin_drop = r_pending || !i_item.link_ready || q32 >= srfq_pkg::RING_RECORDS;
    assign flush_svc  = r_pending || !i_item.link_ready;
    assign q_svc      = flush_svc ? '0 : r_queued;
    assign rs_svc     = flush_svc ? r_write_slot : r_read_slot;
    assign batch_ok   = r_stream && !r_busy && q_svc != '0 && i_item.link_accept;
    assign n_batch    = (32'(q_svc) < srfq_pkg::BATCH_RECORDS) ? 3'(q_svc)
                                                               : 3'(srfq_pkg::BATCH_RECORDS);
    assign slot_sum   = {1'b0, rs_svc} + (SW+1)'(n_batch);
    assign smp_ok     = r_assembling && r_taken < r_h_cnt;
    assign smp_last   = (r_taken + 7'd1) >= r_h_cnt;
    assign lane       = r_taken[1:0];
    assign sword      = srfq_pkg::FIRST_SAMPLE_WORD + WW'(r_taken[6:2]);
    assign sum32      = 32'(r_hdr_sum) + 32'(r_smp_sum) + 32'(r_range);
    assign wlo        = {r_bword, 1'b0};
    assign whi        = {r_bword, 1'b1};

    assign o_stat.go_commit   = i_item.opcode == srfq_pkg::OP_SAMPLE && smp_ok && smp_last;
    assign o_stat.go_batch    = i_item.opcode == srfq_pkg::OP_SERVICE && batch_ok;
    assign o_stat.commit_done = i_cmd.commit && r_cstep == 2'd3;
    assign o_stat.last_beat   = r_brem == 3'd1 && r_bword == srfq_pkg::LAST_BEAT;
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_write_slot = r_write_slot;  n_read_slot = r_read_slot;  n_queued = r_queued;
        n_seq = r_seq;  n_drop = r_drop;  n_stream = r_stream;  n_busy = r_busy;
        n_pending = r_pending;  n_assembling = r_assembling;  n_taken = r_taken;
        n_cstep = r_cstep;  n_brem = r_brem;  n_out_valid = r_out_valid;
        n_h_cnt = r_h_cnt;  n_h_prof = r_h_prof;  n_h_seq = r_h_seq;  n_h_tick = r_h_tick;
        n_h_drop = r_h_drop;  n_range = r_range;  n_smp_sum = r_smp_sum;
        n_hdr_sum = r_hdr_sum;  n_acc = r_acc;  n_bslot = r_bslot;  n_bword = r_bword;
        n_lo_q = r_lo_q;
        n_o_bv = r_o_bv;  n_o_last = r_o_last;  n_o_own = r_o_own;  n_o_str = r_o_str;
        n_o_lo = r_o_lo;  n_o_hi = r_o_hi;  n_o_drop = r_o_drop;  n_o_q = r_o_q;
        we = 1'b0;  waddr = '0;  wdata = '0;  cnt_we = 1'b0;
        rd_en = 1'b0;  raddr = '0;

        if (i_cmd.accept) begin
            case (i_item.opcode)
                srfq_pkg::OP_BEGIN: begin
                    n_assembling = 1'b0;
                    if (begin_ok) begin
                        n_seq = r_seq + 32'd1;
                        if (begin_drop) begin
                            n_drop = r_drop + 32'd1;
                        end else begin
                            n_assembling = 1'b1;
                            n_taken   = '0;
                            n_range   = 1'b0;
                            n_smp_sum = '0;
                            n_h_cnt   = cnt7;
                            n_h_prof  = i_item.profile;
                            n_h_seq   = r_seq;
                            n_h_tick  = i_item.tick;
                            n_h_drop  = r_drop;
                            n_hdr_sum = srfq_pkg::HDR_CONST_SUM
                                + 20'({i_item.profile, i_item.sample_count})
                                + 20'(r_seq[15:0]) + 20'(r_seq[31:16])
                                + 20'(i_item.tick[15:0]) + 20'(i_item.tick[31:16])
                                + 20'(r_drop[15:0]) + 20'(r_drop[31:16]);
                        end
                    end
                end
                srfq_pkg::OP_SAMPLE: begin
                    if (smp_ok) begin
                        n_acc = ((lane == 2'd0) ? 64'd0 : r_acc)
                                | (64'(i_item.sample) << {lane, 4'b0000});
                        if ((lane == 2'd3 || smp_last) && sword != srfq_pkg::SUM_WORD) begin
                            we    = 1'b1;
                            waddr = rec_base(r_write_slot) + AW'(sword);
                            wdata = n_acc;
                        end
                        if (i_item.sample == 16'd0 || i_item.sample > i_ceiling) begin
                            n_range = 1'b1;
                        end
                        n_smp_sum = r_smp_sum + 23'(i_item.sample);
                        n_taken   = r_taken + 7'd1;
                    end
                end
                srfq_pkg::OP_SERVICE: begin
                    if (flush_svc) begin
                        n_pending   = 1'b0;
                        n_drop      = r_drop + q32;
                        n_read_slot = r_write_slot;
                        n_queued    = '0;
                    end
                    if (batch_ok) begin
                        n_busy      = 1'b1;
                        n_read_slot = (slot_sum >= (SW+1)'(srfq_pkg::RING_RECORDS))
                                      ? SW'(slot_sum - (SW+1)'(srfq_pkg::RING_RECORDS))
                                      : SW'(slot_sum);
                        n_queued    = q_svc - CW'(n_batch);
                        n_bslot     = rs_svc;
                        n_bword     = '0;
                        n_brem      = n_batch;
                    end
                end
                srfq_pkg::OP_XFER_DONE: begin
                    n_busy = 1'b0;
                end
                srfq_pkg::OP_LINK_RST: begin
                    n_pending = 1'b1;
                    n_busy    = 1'b0;
                end
                srfq_pkg::OP_START: begin
                    n_stream = 1'b1;
                end
                srfq_pkg::OP_STOP: begin
                    n_stream     = 1'b0;
                    n_drop       = r_drop + q32;
                    n_read_slot  = r_write_slot;
                    n_queued     = '0;
                    n_assembling = 1'b0;
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.commit) begin
            we      = 1'b1;
            n_cstep = r_cstep + 2'd1;
            case (r_cstep)
                2'd0: begin
                    waddr = rec_base(r_write_slot);
                    wdata = {r_h_prof, 1'b0, r_h_cnt, srfq_pkg::REC_LEN, srfq_pkg::MAGIC_WORD};
                end
                2'd1: begin
                    waddr = rec_base(r_write_slot) + AW'(1);
                    wdata = {r_h_tick, r_h_seq};
                end
                2'd2: begin
                    waddr = rec_base(r_write_slot) + AW'(2);
                    wdata = {31'd0, r_range, r_h_drop};
                end
                default: begin
                    // last word: sum, plus the 65th sample when present
                    waddr = rec_base(r_write_slot) + AW'(srfq_pkg::SUM_WORD);
                    wdata = {sum32, (r_h_cnt == 7'(srfq_pkg::MAX_SAMPLES))
                                    ? r_acc[31:0] : 32'd0};
                    cnt_we       = 1'b1;
                    n_write_slot = slot_inc(r_write_slot);
                    n_queued     = r_queued + CW'(1);
                    n_assembling = 1'b0;
                end
            endcase
        end

        if (i_cmd.rd_lo) begin
            rd_en = 1'b1;
            raddr = rec_base(r_bslot) + AW'(wlo);
        end
        if (i_cmd.rd_hi) begin
            rd_en  = 1'b1;
            raddr  = rec_base(r_bslot) + AW'(whi);
            n_lo_q = r_rdata;
        end

        if (i_cmd.load_beat || i_cmd.load_status) begin
            n_out_valid = 1'b1;
            n_o_own     = r_stream || r_busy;
            n_o_str     = r_stream;
            n_o_drop    = r_drop;
            n_o_q       = 6'(q32);
            n_o_bv      = i_cmd.load_beat;
            n_o_last    = i_cmd.load_status || o_stat.last_beat;
            n_o_lo      = '0;
            n_o_hi      = '0;
            if (i_cmd.load_beat) begin
                n_o_lo = srfq_pkg::word_kept(wlo, r_slot_cnt[r_bslot]) ? r_lo_q : 64'd0;
                n_o_hi = srfq_pkg::word_kept(whi, r_slot_cnt[r_bslot]) ? r_rdata : 64'd0;
                if (r_bword == srfq_pkg::LAST_BEAT) begin
                    n_bword = '0;
                    n_bslot = slot_inc(r_bslot);
                    n_brem  = r_brem - 3'd1;
                end else begin
                    n_bword = r_bword + 4'd1;
                end
            end
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_slot <= '0;  r_read_slot <= '0;  r_queued <= '0;
            r_seq <= '0;  r_drop <= '0;  r_stream <= 1'b0;  r_busy <= 1'b0;
            r_pending <= 1'b0;  r_assembling <= 1'b0;  r_taken <= '0;
            r_cstep <= '0;  r_brem <= '0;  r_out_valid <= 1'b0;
        end else begin
            r_write_slot <= n_write_slot;  r_read_slot <= n_read_slot;  r_queued <= n_queued;
            r_seq <= n_seq;  r_drop <= n_drop;  r_stream <= n_stream;  r_busy <= n_busy;
            r_pending <= n_pending;  r_assembling <= n_assembling;  r_taken <= n_taken;
            r_cstep <= n_cstep;  r_brem <= n_brem;  r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_cnt <= n_h_cnt;  r_h_prof <= n_h_prof;  r_h_seq <= n_h_seq;
        r_h_tick <= n_h_tick;  r_h_drop <= n_h_drop;  r_range <= n_range;
        r_smp_sum <= n_smp_sum;  r_hdr_sum <= n_hdr_sum;  r_acc <= n_acc;
        r_bslot <= n_bslot;  r_bword <= n_bword;  r_lo_q <= n_lo_q;
        r_o_bv <= n_o_bv;  r_o_last <= n_o_last;  r_o_own <= n_o_own;  r_o_str <= n_o_str;
        r_o_lo <= n_o_lo;  r_o_hi <= n_o_hi;  r_o_drop <= n_o_drop;  r_o_q <= n_o_q;
        if (cnt_we) begin
            r_slot_cnt[r_write_slot] <= r_h_cnt;
        end
    end

    // record store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rdata <= mem[raddr];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_beat_valid     = r_o_bv;
    assign o_beat_low       = r_o_lo;
    assign o_beat_high      = r_o_hi;
    assign o_beat_last      = r_o_last;
    assign o_owns_link      = r_o_own;
    assign o_stream_enabled = r_o_str;
    assign o_dropped_total  = r_o_drop;
    assign o_queued_records = r_o_q;

endmodule

// ===== test/tb.sv =====
// tb: self-checking bench for scan_record_framer_queue_top; predicts record beats and
// status words per accepted word. Depends on srfq_pkg, srfq_item_if, srfq_result_if.
module tb;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int REC_W = 20;

    typedef struct packed {
        logic        beat_valid;
        logic [63:0] beat_low;
        logic [63:0] beat_high;
        logic        beat_last;
        logic        owns_link;
        logic        stream_enabled;
        logic [31:0] dropped_total;
        logic [5:0]  queued_records;
    } t_res;

    class record_queue_scoreboard;
        logic [63:0] store [srfq_pkg::RING_RECORDS*REC_W];
        int unsigned wr_slot, rd_slot, queued, seq_no, dropped;
        bit stream_on, xfer_busy, rst_pending, assembling, out_of_range;
        int unsigned taken, expected_cnt;
        logic [63:0] hdr [3];
        logic [15:0] ceiling;
        t_res beats_due[$];
        int unsigned errors, words_in, beats_seen, status_seen, records_built;

        function new();
            wr_slot = 0; rd_slot = 0; queued = 0; seq_no = 0; dropped = 0;
            stream_on = 0; xfer_busy = 0; rst_pending = 0; assembling = 0;
            out_of_range = 0; taken = 0; expected_cnt = 0;
            hdr[0] = '0; hdr[1] = '0; hdr[2] = '0;
            ceiling = srfq_pkg::CEILING_RESET;
        endfunction

        function void push_res(bit bv, logic [63:0] lo, logic [63:0] hi, bit last);
            t_res r;
            r.beat_valid = bv; r.beat_low = lo; r.beat_high = hi; r.beat_last = last;
            r.owns_link = stream_on || xfer_busy;
            r.stream_enabled = stream_on;
            r.dropped_total = dropped;
            r.queued_records = queued[5:0];
            beats_due.push_back(r);
        endfunction

        function void flush_ring();
            dropped += queued;
            rd_slot = wr_slot;
            queued = 0;
        endfunction

        function void close_record();
            int unsigned base;
            logic [31:0] sum;
            logic [63:0] w;
            base = wr_slot * REC_W;
            store[base] = hdr[0];
            store[base+1] = hdr[1];
            store[base+2] = hdr[2] | (out_of_range ? 64'h1 << 32 : 64'h0);
            sum = 0;
            for (int b = 0; b < 156; b += 2) begin
                w = store[base + (b >> 3)];
                sum += 32'((w >> ((b & 7) * 8)) & 64'hFFFF);
            end
            store[base + REC_W - 1] |= {sum, 32'h0};
            wr_slot = (wr_slot + 1) % srfq_pkg::RING_RECORDS;
            queued++;
            assembling = 0;
            records_built++;
        endfunction

        function void note_item(srfq_pkg::t_item it);
            int unsigned base, b, n, first;
            words_in++;
            case (it.opcode)
                srfq_pkg::OP_BEGIN: begin
                    assembling = 0;
                    if (stream_on && it.sample_count != 0
                        && it.sample_count <= srfq_pkg::MAX_SAMPLES) begin
                        seq_no++;
                        if (rst_pending || !it.link_ready
                            || queued >= srfq_pkg::RING_RECORDS) begin
                            dropped++;
                        end else begin
                            base = wr_slot * REC_W;
                            for (int i = 0; i < REC_W; i++) store[base+i] = '0;
                            hdr[0] = {it.profile, it.sample_count, srfq_pkg::REC_LEN,
                                      srfq_pkg::MAGIC_WORD};
                            hdr[1] = {it.tick, 32'(seq_no - 1)};
                            hdr[2] = {32'h0, dropped};
                            expected_cnt = it.sample_count;
                            taken = 0;
                            out_of_range = 0;
                            assembling = 1;
                        end
                    end
                end
                srfq_pkg::OP_SAMPLE: begin
                    if (assembling && taken < expected_cnt) begin
                        b = 24 + taken * 2;
                        base = wr_slot * REC_W + (b >> 3);
                        store[base] |= 64'(it.sample) << ((b & 7) * 8);
                        if (it.sample == 0 || it.sample > ceiling) out_of_range = 1;
                        taken++;
                        if (taken >= expected_cnt) close_record();
                    end
                end
                srfq_pkg::OP_SERVICE: begin
                    if (rst_pending || !it.link_ready) begin
                        rst_pending = 0;
                        flush_ring();
                    end
                    if (stream_on && !xfer_busy && queued != 0 && it.link_accept) begin
                        n = queued < srfq_pkg::BATCH_RECORDS ? queued
                                                             : srfq_pkg::BATCH_RECORDS;
                        first = rd_slot;
                        xfer_busy = 1;
                        rd_slot = (rd_slot + n) % srfq_pkg::RING_RECORDS;
                        queued -= n;
                        for (int r = 0; r < n; r++) begin
                            base = ((first + r) % srfq_pkg::RING_RECORDS) * REC_W;
                            for (int w = 0; w < REC_W; w += 2)
                                push_res(1, store[base+w], store[base+w+1],
                                         (r + 1 == n) && (w + 2 >= REC_W));
                        end
                        return;
                    end
                end
                srfq_pkg::OP_XFER_DONE: xfer_busy = 0;
                srfq_pkg::OP_LINK_RST: begin
                    rst_pending = 1;
                    xfer_busy = 0;
                end
                srfq_pkg::OP_START: stream_on = 1;
                srfq_pkg::OP_STOP: begin
                    stream_on = 0;
                    flush_ring();
                    assembling = 0;
                end
                default: ;
            endcase
            push_res(0, '0, '0, 1);
        endfunction

        function void check_result(t_res got);
            t_res exp_r;
            if (got.beat_valid) beats_seen++; else status_seen++;
            if (beats_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word: %p", got);
                return;
            end
            exp_r = beats_due.pop_front();
            if (got !== exp_r) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: expected %p", exp_r);
                    $display("          actual   %p", got);
                end
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [srfq_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    srfq_item_if   item_ch();
    srfq_result_if res_ch();

    scan_record_framer_queue_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item_ch.sink), .o_result(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    record_queue_scoreboard sb = new();
    bit idle_en = 1;
    int hold_req = 0;
    int hold_left = 0;
    int unsigned cfg_errors = 0;

    initial begin
        item_ch.valid = 0; item_ch.opcode = '0; item_ch.sample_count = '0;
        item_ch.profile = '0; item_ch.tick = '0; item_ch.sample = '0;
        item_ch.link_ready = 0; item_ch.link_accept = 0;
        res_ch.ready = 0;
    end

    // receiver: random stalls, plus long hold-offs on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 0;
            end else begin
                res_ch.ready <= !(idle_en && $urandom_range(0, 99) < 33);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_result('{res_ch.beat_valid, res_ch.beat_low, res_ch.beat_high,
                              res_ch.beat_last, res_ch.owns_link, res_ch.stream_enabled,
                              res_ch.dropped_total, res_ch.queued_records});
    end

    function automatic srfq_pkg::t_item mk(logic [2:0] op, logic [7:0] cnt = 8'd0,
                                           logic [15:0] smp = 16'd0, bit rdy = 1,
                                           bit acc = 1);
        srfq_pkg::t_item it;
        it.opcode = op;
        it.sample_count = cnt;
        it.profile = 8'($urandom);
        it.tick = $urandom;
        it.sample = smp;
        it.link_ready = rdy;
        it.link_accept = acc;
        return it;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_word(srfq_pkg::t_item it);
        while (idle_en && $urandom_range(0, 99) < 33) begin
            item_ch.valid <= 0;
            @(negedge i_clk);
        end
        item_ch.valid <= 1;
        item_ch.opcode <= it.opcode;
        item_ch.sample_count <= it.sample_count;
        item_ch.profile <= it.profile;
        item_ch.tick <= it.tick;
        item_ch.sample <= it.sample;
        item_ch.link_ready <= it.link_ready;
        item_ch.link_accept <= it.link_accept;
        do @(posedge i_clk); while (!item_ch.ready);
        sb.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic drain();
        item_ch.valid <= 0;
        while (sb.beats_due.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic apb_access(bit wr, logic [31:0] data);
        psel <= 1; penable <= 0; pwrite <= wr;
        paddr <= srfq_pkg::PADDR_W'(4 * srfq_pkg::REG_CEILING); pwdata <= data;
        @(negedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        if (!wr && prdata[15:0] !== sb.ceiling) begin
            cfg_errors++;
            $display("ceiling readback: expected %h actual %h", sb.ceiling, prdata[15:0]);
        end
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic set_ceiling(logic [15:0] v);
        apb_access(1, {16'($urandom), v});
        sb.ceiling = v;
        apb_access(0, '0);
    endtask

    task automatic send_record(int cnt, int n_smp, bit rdy);
        logic [15:0] s;
        send_word(mk(srfq_pkg::OP_BEGIN, 8'(cnt), 16'd0, rdy));
        for (int i = 0; i < n_smp; i++) begin
            case ($urandom_range(0, 9))
                0: s = 16'd0;
                1: s = 16'($urandom_range(sb.ceiling, 65535));
                2: s = 16'($urandom);
                default: s = 16'($urandom_range(1, sb.ceiling > 0 ? sb.ceiling : 1));
            endcase
            send_word(mk(srfq_pkg::OP_SAMPLE, 8'($urandom), s));
        end
    endtask

    task automatic random_words(int target);
        int start_n, r, cnt;
        start_n = sb.words_in;
        while (sb.words_in - start_n < target) begin
            if (!sb.stream_on && $urandom_range(0, 9) < 8) send_word(mk(srfq_pkg::OP_START));
            r = $urandom_range(0, 99);
            if (r < 60) begin
                case ($urandom_range(0, 19))
                    0: cnt = 65;
                    1: cnt = $urandom_range(0, 255);
                    default: cnt = $urandom_range(1, 6);
                endcase
                send_record(cnt, ($urandom_range(0, 9) == 0) ? cnt / 2 : cnt,
                            $urandom_range(0, 9) != 0);
            end else if (r < 80) begin
                send_word(mk(srfq_pkg::OP_SERVICE, 8'd0, 16'd0, $urandom_range(0, 9) != 0,
                             $urandom_range(0, 6) != 0));
                if ($urandom_range(0, 9) < 7) send_word(mk(srfq_pkg::OP_XFER_DONE));
            end else if (r < 88) send_word(mk(srfq_pkg::OP_XFER_DONE));
            else if (r < 91) send_word(mk(srfq_pkg::OP_LINK_RST));
            else if (r < 95) send_word(mk(srfq_pkg::OP_START));
            else if (r < 97) send_word(mk(srfq_pkg::OP_STOP));
            else send_word(mk(3'($urandom), 8'($urandom), 16'($urandom), 1'($urandom),
                              1'($urandom)));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: edges of counts, every opcode, flush paths
        apb_access(0, '0);
        send_word(mk(srfq_pkg::OP_BEGIN, 8'd1));                // ignored while stopped
        send_word(mk(srfq_pkg::OP_START));
        send_word(mk(srfq_pkg::OP_BEGIN, 8'd1));
        send_word(mk(srfq_pkg::OP_SAMPLE, 8'd0, 16'd0));        // zero sample flags range
        send_word(mk(srfq_pkg::OP_BEGIN, 8'd0));
        send_word(mk(srfq_pkg::OP_BEGIN, 8'd66));
        send_word(mk(srfq_pkg::OP_BEGIN, 8'd255));
        send_record(65, 65, 1);
        send_word(mk(srfq_pkg::OP_SERVICE, 8'd0, 16'd0, 1, 0)); // batch refused
        send_word(mk(srfq_pkg::OP_SERVICE, 8'd0, 16'd0, 1, 1));
        send_word(mk(srfq_pkg::OP_SERVICE, 8'd0, 16'd0, 1, 1)); // busy, no batch sent
        send_word(mk(srfq_pkg::OP_XFER_DONE));
        send_record(2, 2, 0);                                   // link not ready: dropped
        send_record(3, 1, 1);                                   // partial, abandoned
        send_record(2, 2, 1);
        send_word(mk(srfq_pkg::OP_SAMPLE, 8'd0, 16'hFFFF));     // stray sample
        send_word(mk(srfq_pkg::OP_LINK_RST));
        send_record(1, 1, 1);                                   // dropped, reset pending
        send_word(mk(srfq_pkg::OP_SERVICE, 8'd0, 16'd0, 0, 1)); // flush
        send_word(mk(srfq_pkg::OP_STOP));
        send_word(mk(OP_UNUSED));
        drain();

        // fill the ring past full with the output held off
        set_ceiling(16'hFFFF);
        send_word(mk(srfq_pkg::OP_START));
        hold_req = 400;
        for (int i = 0; i < 34; i++) send_record(1, 1, 1);
        for (int i = 0; i < 9; i++) begin
            send_word(mk(srfq_pkg::OP_SERVICE, 8'd0, 16'd0, 1, 1));
            send_word(mk(srfq_pkg::OP_XFER_DONE));
        end
        drain();

        set_ceiling(16'd0);
        random_words(10);
        drain();
        set_ceiling(16'($urandom_range(1, 65534)));
        idle_en = 0;
        random_words(20);
        idle_en = 1;
        random_words(5);
        drain();
        set_ceiling(16'hFFFF);
        random_words(8);
        drain();
        repeat (40) @(negedge i_clk);

        $display("run: %0d words in, %0d records built, %0d beats and %0d status words out",
                 sb.words_in, sb.records_built, sb.beats_seen, sb.status_seen);
        $display("ceilings 0, mid, max and default exercised; ring filled past full");
        if (sb.errors == 0 && cfg_errors == 0 && sb.beats_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d left over", sb.errors + cfg_errors,
                     sb.beats_due.size());
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("timeout");
        $display("TB_ERROR");
        $finish;
    end
endmodule
